>>> hdl/adsr_pkg.sv
`default_nettype none

package adsr_pkg;

  // Fixed-point format of levels and rates
  localparam int FRAC_BITS = 24;
  localparam int LVL_W     = FRAC_BITS + 1;
  localparam logic [LVL_W-1:0] ONE = LVL_W'(1) << FRAC_BITS;

  // Register map of the configuration port
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_RATE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_RATE     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_RATE   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_TARGET = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_MARGIN    = CFG_IDX_W'(4);

  // Reset value of the closeness margin, about 0.005
  localparam logic [LVL_W-1:0] MARGIN_RESET = LVL_W'(83886);

  // Stream data widths, padded to whole bytes
  localparam int IN_DATA_W  = 8;
  localparam int STAGE_W    = 3;
  localparam int OUT_DATA_W = ((LVL_W + STAGE_W + 7) / 8) * 8;

  // Envelope stages
  typedef enum logic [STAGE_W-1:0] {
    ST_IDLE    = 3'd0,
    ST_ATTACK  = 3'd1,
    ST_DECAY   = 3'd2,
    ST_SUSTAIN = 3'd3,
    ST_RELEASE = 3'd4
  } stage_t;

endpackage

`default_nettype wire

>>> hdl/adsr_approach.sv
`default_nettype none

// One-pole step: level moves toward target by |target - level| * rate,
// rounded to nearest, never past the target.
module adsr_approach
  import adsr_pkg::*;
(
  input  wire logic [LVL_W-1:0] level,
  input  wire logic [LVL_W-1:0] target,
  input  wire logic [LVL_W-1:0] rate,
  output logic      [LVL_W-1:0] result
);

  localparam int PROD_W = LVL_W + FRAC_BITS + 1;
  localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

  logic             up;
  logic [LVL_W-1:0] diff;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] rounded;
  logic [PROD_W-FRAC_BITS-1:0] step_raw;
  logic [LVL_W-1:0] step;

  assign up   = (target >= level);
  assign diff = up ? (target - level) : (level - target);

  // Rate below one uses only its fraction bits
  assign prod     = PROD_W'(diff) * PROD_W'(rate[FRAC_BITS-1:0]);
  assign rounded  = prod + HALF;
  assign step_raw = rounded[PROD_W-1:FRAC_BITS];

  // Rate of one or more jumps straight to the target
  always_comb begin
    if (rate[FRAC_BITS] || (step_raw > (PROD_W-FRAC_BITS)'(diff))) begin
      step = diff;
    end else begin
      step = step_raw[LVL_W-1:0];
    end
  end

  assign result = up ? (level + step) : (level - step);

endmodule

`default_nettype wire

>>> hdl/adsr_envelope_generator.sv
`default_nettype none

// ADSR envelope generator with one-pole (exponential) segments. Each input
// item is one sample carrying the gate and retrigger bits; each produces one
// result item with the new Q.24 level (zero while idle) and the stage code.
// The block takes one item per clock while results are taken without stall.
// An accepted item waits in the input register until the output register is
// free. It then passes through the stage logic and the single multiply-add of
// the level update into the output register, which offers its result.
// That multiply-add, which closes the level loop from one sample to the
// next, sets the clock period. Configuration writes are taken whenever the
// block is out of reset; values above 1.0 are saturated to 1.0 on write.
module adsr_envelope_generator
  import adsr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Input samples
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // [0] gate_in, [1] retrig_in
  // Results
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic      [OUT_DATA_W-1:0] m_axis_tdata,  // [24:0] level_out, [27:25] stage_out
  // Configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [LVL_W-1:0]      cfg_data
);

  // Configuration registers
  logic [LVL_W-1:0] attack_rate;
  logic [LVL_W-1:0] decay_rate;
  logic [LVL_W-1:0] release_rate;
  logic [LVL_W-1:0] sustain_target;
  logic [LVL_W-1:0] near_margin;
  logic [LVL_W-1:0] cfg_sat;

  // Envelope state
  stage_t           stage;
  logic [LVL_W-1:0] level;
  logic             prev_trig;

  // Input register
  logic             in_valid;
  logic             in_gate;
  logic             in_retrig;

  // Output register
  logic                  out_valid;
  logic [LVL_W-1:0]      out_level;
  logic [STAGE_W-1:0]    out_stage;

  // Step logic
  logic             advance;
  logic             trig;
  stage_t           stage_next;
  logic [LVL_W-1:0] level_mid;
  logic [LVL_W-1:0] level_step;
  logic [LVL_W-1:0] level_next;
  logic [LVL_W-1:0] tgt;
  logic [LVL_W-1:0] rate;

  assign cfg_ready = !rst;
  assign cfg_sat   = (cfg_data > ONE) ? ONE : cfg_data;

  // Configuration write
  always_ff @(posedge clk) begin
    if (rst) begin
      attack_rate    <= ONE;
      decay_rate     <= ONE;
      release_rate   <= ONE;
      sustain_target <= ONE;
      near_margin    <= MARGIN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ATTACK_RATE:    attack_rate    <= cfg_sat;
        REG_DECAY_RATE:     decay_rate     <= cfg_sat;
        REG_RELEASE_RATE:   release_rate   <= cfg_sat;
        REG_SUSTAIN_TARGET: sustain_target <= cfg_sat;
        REG_NEAR_MARGIN:    near_margin    <= cfg_sat;
        default: ;
      endcase
    end
  end

  // Handshake: the input register moves on when the output register is free
  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !rst && (!in_valid || advance);

  // Stage transitions and segment selection
  always_comb begin
    trig       = in_gate || in_retrig;
    stage_next = stage;
    level_mid  = level;
    if (trig) begin
      if (!prev_trig) begin
        stage_next = ST_ATTACK;
      end
      if (stage_next == ST_IDLE) begin
        stage_next = ST_ATTACK;
      end else if (stage_next == ST_ATTACK &&
                   ({1'b0, level} + {1'b0, near_margin}) >= {1'b0, ONE}) begin
        level_mid  = ONE;
        stage_next = ST_DECAY;
      end else if (stage_next == ST_DECAY &&
                   {1'b0, level} <= ({1'b0, sustain_target} + {1'b0, near_margin})) begin
        level_mid  = sustain_target;
        stage_next = ST_SUSTAIN;
      end
    end else begin
      if (stage_next != ST_IDLE && stage_next != ST_RELEASE) begin
        stage_next = ST_RELEASE;
      end else if (stage_next == ST_RELEASE && level <= near_margin) begin
        level_mid  = '0;
        stage_next = ST_IDLE;
      end
    end

    case (stage_next)
      ST_ATTACK: begin
        tgt  = ONE;
        rate = attack_rate;
      end
      ST_DECAY, ST_SUSTAIN: begin
        tgt  = sustain_target;
        rate = decay_rate;
      end
      ST_RELEASE: begin
        tgt  = '0;
        rate = release_rate;
      end
      default: begin
        tgt  = level_mid;
        rate = ONE;
      end
    endcase
  end

  adsr_approach u_approach (
    .level  (level_mid),
    .target (tgt),
    .rate   (rate),
    .result (level_step)
  );

  // Idle holds the level
  assign level_next = (stage_next == ST_IDLE) ? level_mid : level_step;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_gate   <= s_axis_tdata[0];
      in_retrig <= s_axis_tdata[1];
    end
  end

  // State update and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage     <= ST_IDLE;
      level     <= '0;
      prev_trig <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
      if (in_valid) begin
        stage     <= stage_next;
        level     <= level_next;
        prev_trig <= trig;
      end
    end
    if (advance && in_valid) begin
      out_level <= (stage_next == ST_IDLE) ? '0 : level_next;
      out_stage <= STAGE_W'(stage_next);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_DATA_W-LVL_W-STAGE_W){1'b0}}, out_stage, out_level};

endmodule

`default_nettype wire
